>>> rtl/hkvt_pkg.sv
// Shared constants, codes and field widths of the hashed key-value table.
package hkvt_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_BUCKETS_DEF  = 32;
  localparam int BUCKET_DEPTH_DEF = 4;
  localparam int KEY_WIDTH_DEF    = 32;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Fixed widths of the request and response fields.
  localparam int FIELD_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 6;

  // Bucket count after reset.
  localparam int RESET_BUCKETS = 19;

  // The modulo unit retires this many dividend bits per cycle.
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = FIELD_W / STEP_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_BUCKET_COUNT = 0;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_ADD    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t STAT_HIT         = 3'd0;
  localparam status_t STAT_MISS        = 3'd1;
  localparam status_t STAT_INSERTED    = 3'd2;
  localparam status_t STAT_UPDATED     = 3'd3;
  localparam status_t STAT_REMOVED     = 3'd4;
  localparam status_t STAT_REMOVE_MISS = 3'd5;
  localparam status_t STAT_FULL        = 3'd6;

endpackage

>>> rtl/hkvt_if.sv
// Request and response channel interfaces of the hashed key-value table.
interface hkvt_req_if;
  logic                         valid;
  logic                         ready;
  logic [hkvt_pkg::OP_W-1:0]    op;
  logic [hkvt_pkg::FIELD_W-1:0] key;
  logic [hkvt_pkg::FIELD_W-1:0] new_value;
  logic [hkvt_pkg::FIELD_W-1:0] fallback_value;

  modport source (output valid, op, key, new_value, fallback_value, input ready);
  modport sink (input valid, op, key, new_value, fallback_value, output ready);
endinterface

interface hkvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hkvt_pkg::STATUS_W-1:0] status;
  logic [hkvt_pkg::FIELD_W-1:0]  value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

>>> rtl/hashed_key_value_table.sv
// Requests are handled one at a time; a new request is accepted only while the
// sequencer is idle, and the bucket walk issues one slot read per cycle.
// Reset: synchronous, active high; clears every slot's valid mark at once and
// sets bucket_count to 19. No clearing pass is needed.
module hashed_key_value_table #(
  parameter int MAX_BUCKETS  = hkvt_pkg::MAX_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = hkvt_pkg::BUCKET_DEPTH_DEF,
  parameter int KEY_WIDTH    = hkvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH  = hkvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  hkvt_req_if.sink                          req,
  hkvt_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hkvt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hkvt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hkvt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int FW         = hkvt_pkg::FIELD_W;
  localparam int SLOT_COUNT = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int OW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNTW = $clog2(BUCKET_DEPTH + 1);
  localparam int NW   = $clog2(MAX_BUCKETS + 1);
  // Stored keys and values keep only the bits that the field can carry.
  localparam int KW_S = (KEY_WIDTH < FW) ? KEY_WIDTH : FW;
  localparam int VW_S = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;

  // Configuration register. The register index is the word address; the
  // two low address bits select a byte within the word and are ignored.
  logic [hkvt_pkg::CFG_W-1:0] bucket_count;
  logic                       cfg_sel;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_sel   = (paddr[hkvt_pkg::APB_ADDR_W-1:2] ==
                      (hkvt_pkg::APB_ADDR_W-2)'(hkvt_pkg::REG_BUCKET_COUNT));
  assign cfg_write = psel && penable && pwrite && pready && cfg_sel;
  assign prdata    = cfg_sel ? hkvt_pkg::APB_DATA_W'(bucket_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= hkvt_pkg::CFG_W'(hkvt_pkg::RESET_BUCKETS);
    end else if (cfg_write) begin
      bucket_count <= pwdata[hkvt_pkg::CFG_W-1:0];
    end
  end

  // A count of zero behaves as one bucket, and counts above the table size
  // are clamped to the table size.
  logic [NW-1:0] eff_buckets;

  always_comb begin
    if (bucket_count == '0) begin
      eff_buckets = NW'(1);
    end else if (int'(bucket_count) > MAX_BUCKETS) begin
      eff_buckets = NW'(MAX_BUCKETS);
    end else begin
      eff_buckets = NW'(bucket_count);
    end
  end

  // Request capture. Keys and values are cut to the configured widths here,
  // so every later compare and write works on masked data.
  logic                 in_beat;
  hkvt_pkg::op_t        op_q;
  logic [KW_S-1:0]      key_q;
  logic [VW_S-1:0]      nval_q;
  logic [FW-1:0]        fb_q;

  assign req.ready = (state == S_IDLE);
  assign in_beat   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_q   <= req.op;
      key_q  <= req.key[KW_S-1:0];
      nval_q <= req.new_value[VW_S-1:0];
      fb_q   <= req.fallback_value;
    end
  end

  // The modulo unit produces the bucket index.
  logic          div_busy;
  logic          div_done;
  logic [BW-1:0] div_rem;

  hkvt_mod #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (in_beat),
    .dividend (FW'(req.key[KW_S-1:0])),
    .divisor  (eff_buckets),
    .busy     (div_busy),
    .done     (div_done),
    .remainder(div_rem)
  );

  function automatic logic [SW-1:0] slot_of(input logic [BW-1:0] b, input logic [OW-1:0] o);
    return SW'(b) * SW'(BUCKET_DEPTH) + SW'(o);
  endfunction

  // Bucket walk. The issue counter presents one slot address per cycle to the
  // store, and each slot read is compared in the cycle after it is issued.
  // The first matching slot and the lowest free slot are remembered.
  logic [BW-1:0]   bucket_q;
  logic [CNTW-1:0] issue_cnt;
  logic            issuing;
  logic            cmp_live;
  logic [OW-1:0]   cmp_off;
  logic            hit_found;
  logic [OW-1:0]   hit_off;
  logic [VW_S-1:0] hit_val;
  logic            free_found;
  logic [OW-1:0]   free_off;
  logic            cmp_hit;
  logic            cmp_free;

  logic [SLOT_COUNT-1:0] slot_valid;
  logic [KW_S-1:0]       rd_key;
  logic [VW_S-1:0]       rd_val;

  assign issuing  = (state == S_SCAN) && (issue_cnt < CNTW'(BUCKET_DEPTH));
  assign cmp_hit  = cmp_live && slot_valid[slot_of(bucket_q, cmp_off)] && (rd_key == key_q);
  assign cmp_free = cmp_live && !slot_valid[slot_of(bucket_q, cmp_off)];

  // Completion. The result is committed only once the output register is
  // free, so the table update and the response capture happen together.
  logic               fin_go;
  logic               mem_we;
  logic [SW-1:0]      mem_waddr;
  hkvt_pkg::status_t  res_status;
  logic [FW-1:0]      res_value;

  assign fin_go    = (state == S_FIN) && (!rsp.valid || rsp.ready);
  assign mem_we    = fin_go && (op_q == hkvt_pkg::OP_ADD) && (hit_found || free_found);
  assign mem_waddr = hit_found ? slot_of(bucket_q, hit_off) : slot_of(bucket_q, free_off);

  always_comb begin
    res_value = '0;
    unique case (op_q)
      hkvt_pkg::OP_ADD: begin
        if (hit_found) begin
          res_status = hkvt_pkg::STAT_UPDATED;
        end else if (free_found) begin
          res_status = hkvt_pkg::STAT_INSERTED;
        end else begin
          res_status = hkvt_pkg::STAT_FULL;
        end
      end
      hkvt_pkg::OP_REMOVE: begin
        res_status = hit_found ? hkvt_pkg::STAT_REMOVED : hkvt_pkg::STAT_REMOVE_MISS;
      end
      default: begin
        // Lookup, and also the unused op code, which changes nothing.
        if (hit_found) begin
          res_status = hkvt_pkg::STAT_HIT;
          res_value  = FW'(hit_val);
        end else begin
          res_status = hkvt_pkg::STAT_MISS;
          res_value  = fb_q;
        end
      end
    endcase
  end

  hkvt_store #(
    .ADDR_W(SW),
    .DEPTH (SLOT_COUNT),
    .KEY_W (KW_S),
    .VAL_W (VW_S)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wkey (key_q),
    .wval (nval_q),
    .re   (issuing),
    .raddr(slot_of(bucket_q, issue_cnt[OW-1:0])),
    .rkey (rd_key),
    .rval (rd_val)
  );

  // Sequencer. When the last slot is compared no read is being issued, so
  // the compare stage empties by itself as the walk ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmp_live <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_live <= issuing;
          if (cmp_live && (cmp_off == OW'(BUCKET_DEPTH - 1))) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Walk bookkeeping; cleared when the bucket index arrives.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      bucket_q   <= div_rem;
      issue_cnt  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
        cmp_off   <= issue_cnt[OW-1:0];
      end
      if (cmp_hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_off   <= cmp_off;
        hit_val   <= rd_val;
      end
      if (cmp_free && !free_found) begin
        free_found <= 1'b1;
        free_off   <= cmp_off;
      end
    end
  end

  // Valid marks live in flip-flops so that reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (fin_go) begin
      if (op_q == hkvt_pkg::OP_ADD && !hit_found && free_found) begin
        slot_valid[slot_of(bucket_q, free_off)] <= 1'b1;
      end else if (op_q == hkvt_pkg::OP_REMOVE && hit_found) begin
        slot_valid[slot_of(bucket_q, hit_off)] <= 1'b0;
      end
    end
  end

  // Output register. It holds a finished response until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fin_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp.status    <= res_status;
      rsp.value_out <= res_value;
    end
  end

  // The modulo unit only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("modulo unit finished outside the divide phase");

  // An accepted request starts the modulo unit in the next cycle.
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_DIV) && div_busy)
    else $error("accepted request did not start the modulo unit");

  // Valid marks change only when a request completes.
  a_valid_on_fin: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (slot_valid != $past(slot_valid))) |-> $past(fin_go))
    else $error("valid marks changed outside request completion");

  // Only hits and misses carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != hkvt_pkg::STAT_HIT && rsp.status != hkvt_pkg::STAT_MISS)
      |-> rsp.value_out == '0)
    else $error("nonzero value on a response that carries none");

endmodule

>>> rtl/hkvt_mod.sv
// Iterative modulo unit: key modulo bucket count, a few quotient bits per cycle.
module hkvt_mod #(
  parameter int MAX_BUCKETS = hkvt_pkg::MAX_BUCKETS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [hkvt_pkg::FIELD_W-1:0]              dividend,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]          divisor,
  output logic                                      busy,
  output logic                                      done,
  output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] remainder
);

  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int RW = NW + 1;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int FW = hkvt_pkg::FIELD_W;

  logic [FW-1:0]                  quo;
  logic [RW-1:0]                  rem;
  logic [hkvt_pkg::DIV_CNT_W-1:0] cnt;
  logic [FW-1:0]                  quo_next;
  logic [RW-1:0]                  rem_next;

  // Restoring division, STEP_BITS dependent subtract-compare steps per cycle.
  always_comb begin
    logic [RW-1:0] r;
    logic [FW-1:0] q;
    r = rem;
    q = quo;
    for (int j = 0; j < hkvt_pkg::STEP_BITS; j++) begin
      r = {r[RW-2:0], q[FW-1]};
      q = {q[FW-2:0], 1'b0};
      if (r >= RW'(divisor)) begin
        r = r - RW'(divisor);
      end
    end
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= hkvt_pkg::DIV_CNT_W'(hkvt_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == hkvt_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign remainder = rem[BW-1:0];

endmodule

>>> rtl/hkvt_store.sv
// Key and value storage of all slots, one write port and one registered read port.
module hkvt_store #(
  parameter int ADDR_W = 7,
  parameter int DEPTH  = 128,
  parameter int KEY_W  = 32,
  parameter int VAL_W  = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [KEY_W-1:0]  wkey,
  input  logic [VAL_W-1:0]  wval,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [KEY_W-1:0]  rkey,
  output logic [VAL_W-1:0]  rval
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rkey <= key_mem[raddr];
      rval <= val_mem[raddr];
    end
  end

endmodule
